// ===== rtl/fssa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package fssa_pkg;

  localparam int TABLE_WIDTH = 16;
  localparam int TILE_MAX_W  = 64;
  localparam int TILE_MAX_H  = 64;
  localparam int CHANNELS    = 3;

  localparam int TBL_SIZE = TABLE_WIDTH * TABLE_WIDTH;
  localparam int TBL_AW   = $clog2(TBL_SIZE);
  localparam int TC_W     = (TABLE_WIDTH > 2) ? $clog2(TABLE_WIDTH) : 1;
  localparam int NPIX     = TILE_MAX_W * TILE_MAX_H;
  localparam int PIX_AW   = $clog2(NPIX);
  localparam int LX_W     = $clog2(TILE_MAX_W);
  localparam int LY_W     = $clog2(TILE_MAX_H);

  // field widths
  localparam int POS_W  = 20;
  localparam int RAD_W  = 24;
  localparam int WGT_W  = 16;
  localparam int FV_W   = 16;
  localparam int E_W    = 48;
  localparam int W_W    = 40;
  localparam int RW_W   = RAD_W + WGT_W;
  localparam int TERM_W = RW_W + FV_W - 14 + 1;
  localparam int PIX_W  = CHANNELS * E_W + W_W;
  localparam int CRD_W  = 15;
  localparam int D_W    = 22;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [1:0] {
    FN_LOAD   = 2'd0,
    FN_SAMPLE = 2'd1,
    FN_READ   = 2'd2
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X = 4'd0,
    REG_ORIGIN_Y = 4'd1,
    REG_TILE_W   = 4'd2,
    REG_TILE_H   = 4'd3,
    REG_RADIUS_X = 4'd4,
    REG_RADIUS_Y = 4'd5,
    REG_INV_X    = 4'd6,
    REG_INV_Y    = 4'd7
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SPAN,
    ST_COORD,
    ST_READ,
    ST_MUL,
    ST_WRITE,
    ST_RD_ISSUE,
    ST_RD_OUT
  } state_t;

  // settings as seen by the datapath, tile size already clamped
  typedef struct packed {
    logic [11:0] origin_x;
    logic [11:0] origin_y;
    logic [6:0]  tile_w;
    logic [6:0]  tile_h;
    logic [9:0]  radius_x;
    logic [9:0]  radius_y;
    logic [15:0] inv_x;
    logic [15:0] inv_y;
  } cfg_t;

endpackage
`default_nettype wire

// ===== rtl/fssa_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface fssa_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [19:0] pos_x;
  logic [19:0] pos_y;
  logic [23:0] radiance_r;
  logic [23:0] radiance_g;
  logic [23:0] radiance_b;
  logic [15:0] splat_weight;
  logic [7:0]  table_index;
  logic signed [15:0] table_value;

  modport source (output valid, func, pos_x, pos_y, radiance_r, radiance_g, radiance_b,
                  splat_weight, table_index, table_value, input ready);
  modport sink   (input valid, func, pos_x, pos_y, radiance_r, radiance_g, radiance_b,
                  splat_weight, table_index, table_value, output ready);
endinterface
`default_nettype wire

// ===== rtl/fssa_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface fssa_out_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] energy_r;
  logic signed [47:0] energy_g;
  logic signed [47:0] energy_b;
  logic signed [39:0] weight_sum;
  logic               out_of_tile;

  modport source (output valid, energy_r, energy_g, energy_b, weight_sum, out_of_tile,
                  input ready);
  modport sink   (input valid, energy_r, energy_g, energy_b, weight_sum, out_of_tile,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/fssa_cfg_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface fssa_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/fssa_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module fssa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// ===== rtl/fssa_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none
module fssa_cfg
  import fssa_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  fssa_cfg_if.sink  cfg_ch,
  output cfg_t      cfg
);
  logic [11:0] origin_x_r, origin_y_r;
  logic [6:0]  tile_w_r, tile_h_r;
  logic [9:0]  radius_x_r, radius_y_r;
  logic [15:0] inv_x_r, inv_y_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
      tile_w_r   <= 7'd64;
      tile_h_r   <= 7'd64;
      radius_x_r <= 10'd512;
      radius_y_r <= 10'd512;
      inv_x_r    <= 16'd2048;
      inv_y_r    <= 16'd2048;
    end else if (cfg_ch.valid) begin
      case (cfg_reg_t'(cfg_ch.index))
        REG_ORIGIN_X: origin_x_r <= cfg_ch.data[11:0];
        REG_ORIGIN_Y: origin_y_r <= cfg_ch.data[11:0];
        REG_TILE_W:   tile_w_r   <= cfg_ch.data[6:0];
        REG_TILE_H:   tile_h_r   <= cfg_ch.data[6:0];
        REG_RADIUS_X: radius_x_r <= cfg_ch.data[9:0];
        REG_RADIUS_Y: radius_y_r <= cfg_ch.data[9:0];
        REG_INV_X:    inv_x_r    <= cfg_ch.data;
        REG_INV_Y:    inv_y_r    <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // oversize tiles clamp to the store size
  always_comb begin
    cfg.origin_x = origin_x_r;
    cfg.origin_y = origin_y_r;
    cfg.tile_w   = (32'(tile_w_r) > TILE_MAX_W) ? 7'(TILE_MAX_W) : tile_w_r;
    cfg.tile_h   = (32'(tile_h_r) > TILE_MAX_H) ? 7'(TILE_MAX_H) : tile_h_r;
    cfg.radius_x = radius_x_r;
    cfg.radius_y = radius_y_r;
    cfg.inv_x    = inv_x_r;
    cfg.inv_y    = inv_y_r;
  end
endmodule
`default_nettype wire

// ===== rtl/filtered_sample_splat_accumulator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel   dir  beat carries
// in_ch     in   func, sample position, radiance, weight, table index and value
// out_ch    out  pixel energies, weight sum, out_of_tile (read pixel only)
// cfg_ch    in   register index and data, always ready
//
// after reset a clearing pass zeroes the pixel store, no input taken
// load table word, unknown func: done in idle; read pixel: issue, then output,
// held while the output register is full; add sample: span, then per covered
// pixel coordinates, read, multiply, write (one read-modify-write per pixel)
// one item at a time; a finished result waits in the output register
module filtered_sample_splat_accumulator
  import fssa_pkg::*;
(
  input wire logic   clk,
  input wire logic   rst_n,
  fssa_in_if.sink    in_ch,
  fssa_out_if.source out_ch,
  fssa_cfg_if.sink   cfg_ch
);
  cfg_t cfg;

  fssa_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  state_t state_r, state_nxt;

  // latched item
  logic [POS_W-1:0] pos_x_r, pos_y_r;
  logic [RAD_W-1:0] rad_in [CHANNELS];
  logic [RW_W-1:0]  rw_r [CHANNELS];

  // span and walk
  logic signed [CRD_W-1:0] x0_r, x1_r, y1_r, x_r, y_r;
  logic signed [CRD_W-1:0] sx0, sx1, sy0, sy1;
  logic signed [D_W-1:0]   dx, dy;
  logic [TC_W-1:0]         cx_r, cy_r;
  logic [PIX_AW-1:0]       pix_addr_r, pix_addr_c;
  logic [PIX_AW-1:0]       clr_cnt_r;

  // memories
  logic              tbl_we, tbl_re;
  logic [TBL_AW-1:0] tbl_waddr, tbl_raddr;
  logic [FV_W-1:0]   tbl_rdata;
  logic              pix_we, pix_re;
  logic [PIX_AW-1:0] pix_waddr, pix_raddr;
  logic [PIX_W-1:0]  pix_wdata, pix_rdata, acc_word;

  logic signed [TERM_W-1:0]      term_r [CHANNELS];
  logic signed [RW_W+FV_W:0]     prod_c [CHANNELS];
  logic signed [FV_W-1:0]        fv_r;

  // read pixel
  logic [POS_W-1:0] rd_lx, rd_ly;
  logic             rd_inside, rd_inside_r;

  // output register
  logic               out_valid_r;
  logic signed [E_W-1:0] out_e_r [3];
  logic signed [W_W-1:0] out_w_r;
  logic               out_oot_r;

  logic in_acc, x_last, y_last, clr_last, span_empty;

  assign in_acc = in_ch.valid && in_ch.ready;
  assign rad_in[0] = in_ch.radiance_r;
  if (CHANNELS > 1) begin : g_rad_g
    assign rad_in[1] = in_ch.radiance_g;
  end
  if (CHANNELS > 2) begin : g_rad_b
    assign rad_in[2] = in_ch.radiance_b;
  end

  // first covered pixel on one axis: ceil((d - r) / 256) clipped to the tile
  function automatic logic signed [CRD_W-1:0] span_lo(
    input logic signed [D_W-1:0] d, input logic [9:0] r, input logic [11:0] org);
    logic signed [D_W-1:0]   t;
    logic signed [CRD_W-1:0] a, o;
    t = (d - $signed(D_W'(r)) + D_W'(255)) >>> 8;
    a = t[CRD_W-1:0];
    o = $signed(CRD_W'(org));
    return (a > o) ? a : o;
  endfunction

  // exclusive end: floor((d + r) / 256) + 1 clipped to the tile
  function automatic logic signed [CRD_W-1:0] span_hi(
    input logic signed [D_W-1:0] d, input logic [9:0] r, input logic [11:0] org,
    input logic [6:0] size);
    logic signed [D_W-1:0]   t;
    logic signed [CRD_W-1:0] b, e;
    t = ((d + $signed(D_W'(r))) >>> 8) + D_W'(1);
    b = t[CRD_W-1:0];
    e = $signed(CRD_W'(org) + CRD_W'(size));
    return (b < e) ? b : e;
  endfunction

  // |offset| is bounded by the radius inside the span, so 11 bits hold it
  function automatic logic [TC_W-1:0] coord(
    input logic signed [CRD_W-1:0] p, input logic signed [D_W-1:0] d,
    input logic [15:0] inv);
    logic signed [CRD_W+7:0] off;
    logic [10:0]             a;
    logic [26:0]             pr;
    logic [33:0]             c;
    off = $signed({p, 8'b0}) - (CRD_W+8)'(d);
    a   = off[CRD_W+7] ? 11'(-off) : off[10:0];
    pr  = 27'(a) * 27'(inv);
    c   = (34'(pr) * 34'(TABLE_WIDTH)) >> 20;
    return (c > 34'(TABLE_WIDTH - 1)) ? TC_W'(TABLE_WIDTH - 1) : TC_W'(c);
  endfunction

  assign dx = $signed(D_W'(pos_x_r)) - D_W'(128);
  assign dy = $signed(D_W'(pos_y_r)) - D_W'(128);
  assign sx0 = span_lo(dx, cfg.radius_x, cfg.origin_x);
  assign sx1 = span_hi(dx, cfg.radius_x, cfg.origin_x, cfg.tile_w);
  assign sy0 = span_lo(dy, cfg.radius_y, cfg.origin_y);
  assign sy1 = span_hi(dy, cfg.radius_y, cfg.origin_y, cfg.tile_h);
  assign span_empty = (sx0 >= sx1) || (sy0 >= sy1);

  assign x_last   = (x_r + CRD_W'(1)) >= x1_r;
  assign y_last   = (y_r + CRD_W'(1)) >= y1_r;
  assign clr_last = (clr_cnt_r == PIX_AW'(NPIX - 1));

  // pixel word of the walk position
  always_comb begin
    logic [LX_W-1:0] lx;
    logic [LY_W-1:0] ly;
    lx = LX_W'(x_r - $signed(CRD_W'(cfg.origin_x)));
    ly = LY_W'(y_r - $signed(CRD_W'(cfg.origin_y)));
    pix_addr_c = PIX_AW'(16'(ly) * 16'(cfg.tile_w) + 16'(lx));
  end

  // read pixel position
  assign rd_lx = pos_x_r - POS_W'(cfg.origin_x);
  assign rd_ly = pos_y_r - POS_W'(cfg.origin_y);
  assign rd_inside = (pos_x_r >= POS_W'(cfg.origin_x)) &&
                     (pos_x_r < POS_W'(13'(cfg.origin_x) + 13'(cfg.tile_w))) &&
                     (pos_y_r >= POS_W'(cfg.origin_y)) &&
                     (pos_y_r < POS_W'(13'(cfg.origin_y) + 13'(cfg.tile_h)));

  // radiance times weight times filter value, full width before the shift
  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      prod_c[c] = $signed({1'b0, rw_r[c]}) * $signed(tbl_rdata);
    end
  end

  // saturating accumulate of the fetched pixel word
  always_comb begin
    logic signed [E_W:0] se;
    logic signed [W_W:0] sw;
    acc_word = pix_rdata;
    for (int c = 0; c < CHANNELS; c++) begin
      se = $signed((E_W+1)'($signed(pix_rdata[c*E_W +: E_W]))) + (E_W+1)'(term_r[c]);
      if (se[E_W] != se[E_W-1]) begin
        acc_word[c*E_W +: E_W] = se[E_W] ? {1'b1, {(E_W-1){1'b0}}} : {1'b0, {(E_W-1){1'b1}}};
      end else begin
        acc_word[c*E_W +: E_W] = se[E_W-1:0];
      end
    end
    sw = $signed((W_W+1)'($signed(pix_rdata[CHANNELS*E_W +: W_W]))) + (W_W+1)'(fv_r);
    if (sw[W_W] != sw[W_W-1]) begin
      acc_word[CHANNELS*E_W +: W_W] = sw[W_W] ? {1'b1, {(W_W-1){1'b0}}} : {1'b0, {(W_W-1){1'b1}}};
    end else begin
      acc_word[CHANNELS*E_W +: W_W] = sw[W_W-1:0];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_last) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.func == FN_SAMPLE) state_nxt = ST_SPAN;
          else if (in_ch.func == FN_READ) state_nxt = ST_RD_ISSUE;
        end
      end
      ST_SPAN:     state_nxt = span_empty ? ST_IDLE : ST_COORD;
      ST_COORD:    state_nxt = ST_READ;
      ST_READ:     state_nxt = ST_MUL;
      ST_MUL:      state_nxt = ST_WRITE;
      ST_WRITE:    state_nxt = (x_last && y_last) ? ST_IDLE : ST_COORD;
      ST_RD_ISSUE: state_nxt = ST_RD_OUT;
      ST_RD_OUT:   if (!out_valid_r || out_ch.ready) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // memory control and ready
  always_comb begin
    in_ch.ready = 1'b0;
    tbl_we    = 1'b0;
    tbl_waddr = in_ch.table_index[TBL_AW-1:0];
    tbl_re    = 1'b0;
    tbl_raddr = TBL_AW'(32'(cy_r) * TABLE_WIDTH + 32'(cx_r));
    pix_we    = 1'b0;
    pix_waddr = pix_addr_r;
    pix_wdata = acc_word;
    pix_re    = 1'b0;
    pix_raddr = pix_addr_r;
    case (state_r)
      ST_CLEAR: begin
        pix_we    = 1'b1;
        pix_waddr = clr_cnt_r;
        pix_wdata = '0;
      end
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        // indexes past the table are dropped
        tbl_we = in_ch.valid && (in_ch.func == FN_LOAD) &&
                 (32'(in_ch.table_index) < TBL_SIZE);
      end
      ST_READ: begin
        tbl_re = 1'b1;
        pix_re = 1'b1;
      end
      ST_WRITE: pix_we = 1'b1;
      ST_RD_ISSUE: begin
        pix_re    = 1'b1;
        pix_raddr = PIX_AW'(16'(rd_ly[LY_W-1:0]) * 16'(cfg.tile_w) + 16'(rd_lx[LX_W-1:0]));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_cnt_r <= clr_cnt_r + PIX_AW'(1);
      if (state_r == ST_RD_OUT && (!out_valid_r || out_ch.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_acc) begin
      pos_x_r <= in_ch.pos_x;
      pos_y_r <= in_ch.pos_y;
      for (int c = 0; c < CHANNELS; c++) begin
        rw_r[c] <= RW_W'(rad_in[c]) * RW_W'(in_ch.splat_weight);
      end
    end
    if (state_r == ST_SPAN) begin
      x0_r <= sx0; x1_r <= sx1; y1_r <= sy1;
      x_r  <= sx0; y_r  <= sy0;
    end
    if (state_r == ST_COORD) begin
      cx_r       <= coord(x_r, dx, cfg.inv_x);
      cy_r       <= coord(y_r, dy, cfg.inv_y);
      pix_addr_r <= pix_addr_c;
    end
    if (state_r == ST_MUL) begin
      fv_r <= $signed(tbl_rdata);
      for (int c = 0; c < CHANNELS; c++) begin
        term_r[c] <= TERM_W'(prod_c[c] >>> 14);
      end
    end
    if (state_r == ST_WRITE) begin
      if (x_last) begin
        x_r <= x0_r;
        y_r <= y_r + CRD_W'(1);
      end else begin
        x_r <= x_r + CRD_W'(1);
      end
    end
    if (state_r == ST_RD_ISSUE) rd_inside_r <= rd_inside;
    if (state_r == ST_RD_OUT && (!out_valid_r || out_ch.ready)) begin
      // channels past CHANNELS and pixels outside the tile read as zero
      for (int c = 0; c < 3; c++) begin
        if (c < CHANNELS && rd_inside_r) begin
          out_e_r[c] <= $signed(pix_rdata[c*E_W +: E_W]);
        end else begin
          out_e_r[c] <= '0;
        end
      end
      out_w_r   <= rd_inside_r ? $signed(pix_rdata[CHANNELS*E_W +: W_W]) : '0;
      out_oot_r <= !rd_inside_r;
    end
  end

  fssa_ram #(.WIDTH(FV_W), .DEPTH(TBL_SIZE)) u_tbl_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (in_ch.table_value),
    .re    (tbl_re),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  // one word per pixel: energies of all channels and the weight sum
  fssa_ram #(.WIDTH(PIX_W), .DEPTH(NPIX)) u_pix_ram (
    .clk   (clk),
    .we    (pix_we),
    .waddr (pix_waddr),
    .wdata (pix_wdata),
    .re    (pix_re),
    .raddr (pix_raddr),
    .rdata (pix_rdata)
  );

  assign out_ch.valid       = out_valid_r;
  assign out_ch.energy_r    = out_e_r[0];
  assign out_ch.energy_g    = out_e_r[1];
  assign out_ch.energy_b    = out_e_r[2];
  assign out_ch.weight_sum  = out_w_r;
  assign out_ch.out_of_tile = out_oot_r;
endmodule
`default_nettype wire

// ===== rtl/fssa_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none
module fssa_chk
  import fssa_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [1:0]  in_func,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [47:0] out_energy_r,
  input wire logic [47:0] out_energy_g,
  input wire logic [47:0] out_energy_b,
  input wire logic [39:0] out_weight_sum,
  input wire logic        out_of_tile
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result beat dropped");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_energy_r) && $stable(out_weight_sum))
    else $error("stalled result changed");

  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_func == FN_READ |=> !in_ready)
    else $error("input taken during pixel read");

  a_oot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_of_tile |-> out_energy_r == '0 && out_energy_g == '0 &&
    out_energy_b == '0 && out_weight_sum == '0) else $error("outside pixel not zero");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready)) else $error("result without read");
endmodule

bind filtered_sample_splat_accumulator fssa_chk u_fssa_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .in_func        (in_ch.func),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_energy_r   (out_ch.energy_r),
  .out_energy_g   (out_ch.energy_g),
  .out_energy_b   (out_ch.energy_b),
  .out_weight_sum (out_ch.weight_sum),
  .out_of_tile    (out_ch.out_of_tile)
);
`default_nettype wire
